[sv/range_minimum_segment_tree_macros.svh]
// ----------------------------------------------------------------------------
// range minimum segment tree assertion macros
// concurrent checks clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RANGE_MINIMUM_SEGMENT_TREE_MACROS_SVH
`define RANGE_MINIMUM_SEGMENT_TREE_MACROS_SVH

`ifndef SYNTHESIS

`define RMST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rmst assertion failed");

`define RMST_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rmst forbidden condition seen");

`else

`define RMST_ASSERT(label, prop)

`define RMST_NEVER(label, cond)

`endif

`endif

[sv/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// range minimum segment tree package
// field widths, the empty-range value and the request opcodes
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int VALUE_W = 31;
    localparam int IDX_W   = 10;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]   index_t;

    localparam value_t TOP_VALUE = 31'h7FFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

[sv/rmst_ram.sv]
// ----------------------------------------------------------------------------
// rmst generic ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module rmst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/range_minimum_segment_tree.sv]
// ----------------------------------------------------------------------------
// range minimum segment tree
// Keeps the minima of a binary tree over LEAVES values in one node RAM.
//
// request channel: req_valid / req_stall with opcode, index_or_start,
// range_end and new_value. A write stores new_value in one leaf and gives
// no result; a query gives one result on res_valid / res_stall carrying the
// minimum over index_or_start..range_end (2^31-1 for an empty range).
// One request is worked on at a time; req_stall stays high until it is done.
// After reset the node RAM is swept to 2^31-1, one node a cycle, over all 2*P
// nodes (P = LEAVES rounded up to a power of two, 1024 by default) while
// requests are stalled.
// A write updates one node per tree level, paced by the single RAM read port
// fetching each sibling.
// In a query each level costs up to two node reads through the same port
// plus one shift step.
// A result waits in an output register while res_stall is high; the
// sequencer holds a finished query until that register is free.
// ----------------------------------------------------------------------------
`include "range_minimum_segment_tree_macros.svh"

module range_minimum_segment_tree #(
    parameter int LEAVES = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  opcode,
    input  rmst_pkg::index_t      index_or_start,
    input  rmst_pkg::index_t      range_end,
    input  rmst_pkg::value_t      new_value,
    output logic                  res_valid,
    input  logic                  res_stall,
    output rmst_pkg::value_t      minimum
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int AW     = LEVELS + 1;
    localparam int DEPTH  = 2 ** AW;

    localparam logic [31:0] LEAVES_W = 32'(LEAVES);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_UPD_LEAF = 3'd2;
    localparam logic [2:0] ST_UPD_UP   = 3'd3;
    localparam logic [2:0] ST_QUERY    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    pos_reg, pos_next;
    rmst_pkg::value_t cur_reg, cur_next;
    logic [AW:0]      lo_reg, lo_next;
    logic [AW:0]      hi_reg, hi_next;
    rmst_pkg::value_t best_reg, best_next;
    logic             pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    rmst_pkg::value_t res_min_reg, res_min_next;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    rmst_pkg::value_t mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;
    rmst_pkg::value_t mem_rd;

    logic             req_accept;
    logic             res_load;
    logic [31:0]      start_w;
    logic [31:0]      end_w;
    logic [31:0]      end_cl;
    logic             range_empty;
    logic [AW-1:0]    parent;
    rmst_pkg::value_t up_min;
    rmst_pkg::value_t merged;
    logic [AW:0]      hi_dec;

    rmst_ram #(
        .WIDTH (rmst_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_en   (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_valid  = res_valid_reg;
    assign minimum    = res_min_reg;

    assign start_w     = 32'(index_or_start);
    assign end_w       = 32'(range_end);
    assign end_cl      = (end_w >= LEAVES_W) ? (LEAVES_W - 32'd1) : end_w;
    assign range_empty = (start_w >= LEAVES_W) || (start_w > end_cl);

    assign parent = {1'b0, pos_reg[AW-1:1]};
    assign up_min = (mem_rd < cur_reg) ? mem_rd : cur_reg;
    assign merged = (pend_reg && (mem_rd < best_reg)) ? mem_rd : best_reg;
    assign hi_dec = hi_reg - (AW+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        pend_next      = 1'b0;
        res_load       = 1'b0;
        res_min_next   = res_min_reg;
        mem_we         = 1'b0;
        mem_wa         = pos_reg;
        mem_wd         = cur_reg;
        mem_re         = 1'b0;
        mem_ra         = pos_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = rmst_pkg::TOP_VALUE;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (opcode == rmst_pkg::OP_WRITE)
                    begin
                        if (start_w < LEAVES_W)
                        begin
                            pos_next   = {1'b1, start_w[LEVELS-1:0]};
                            cur_next   = new_value;
                            state_next = ST_UPD_LEAF;
                        end
                    end
                    else
                    begin
                        best_next  = rmst_pkg::TOP_VALUE;
                        state_next = ST_QUERY;
                        if (range_empty)
                        begin
                            lo_next = '0;
                            hi_next = '0;
                        end
                        else
                        begin
                            lo_next = {2'b01, start_w[LEVELS-1:0]};
                            hi_next = {2'b01, end_cl[LEVELS-1:0]} + (AW+1)'(1);
                        end
                    end
                end
            end
            ST_UPD_LEAF:
            begin
                mem_we     = 1'b1;
                mem_re     = 1'b1;
                mem_ra     = {pos_reg[AW-1:1], ~pos_reg[0]};
                state_next = ST_UPD_UP;
            end
            ST_UPD_UP:
            begin
                mem_we   = 1'b1;
                mem_wa   = parent;
                mem_wd   = up_min;
                cur_next = up_min;
                pos_next = parent;
                if (parent == AW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_ra = {parent[AW-1:1], ~parent[0]};
                end
            end
            ST_QUERY:
            begin
                best_next = merged;
                priority if (lo_reg >= hi_reg)
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_load     = 1'b1;
                        res_min_next = merged;
                        state_next   = ST_IDLE;
                    end
                end
                else if (lo_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_ra    = lo_reg[AW-1:0];
                    lo_next   = lo_reg + (AW+1)'(1);
                    pend_next = 1'b1;
                end
                else if (hi_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_ra    = hi_dec[AW-1:0];
                    hi_next   = hi_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    lo_next = lo_reg >> 1;
                    hi_next = hi_reg >> 1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        res_min_reg <= res_min_next;
    end

    // checks
    `RMST_NEVER(a_no_accept_in_clear, (state_reg == ST_CLEAR) && req_accept)
    `RMST_ASSERT(a_upd_pos_nonzero, (state_reg == ST_UPD_UP) |-> (pos_reg != '0))
    `RMST_ASSERT(a_load_from_query, res_load |-> (state_reg == ST_QUERY))
    `RMST_ASSERT(a_query_bounds, (state_reg == ST_QUERY) |-> (lo_reg <= hi_reg))

endmodule

[tb/range_minimum_segment_tree_test.sv]
// ----------------------------------------------------------------------------
// range minimum segment tree testbench
// Drives write and query requests through the valid/stall request channel,
// keeps a copy of the leaf values to predict every range minimum, and checks
// each minimum in order. The directed table covers reset values, extremes and
// empty ranges. The random part follows with windowed indices, varied values
// and random idling on both sides, including two long receiver hold-offs.
// ----------------------------------------------------------------------------
module range_minimum_segment_tree_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES       = 1024;
    localparam int RANDOM_ITEMS = 1680;
    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int DIRECTED_N   = 23;

    typedef struct packed {
        logic             op;
        rmst_pkg::index_t start;
        rmst_pkg::index_t last;
        rmst_pkg::value_t value;
        logic             known;
        rmst_pkg::value_t want;
    } stim_row_t;

    localparam rmst_pkg::value_t V_FIVES  = 31'h5555_5555;
    localparam rmst_pkg::value_t V_TWOS   = 31'h2AAA_AAAA;
    localparam rmst_pkg::value_t V_ALMOST = 31'h7FFF_FFFE;

    // typed-in minima only where they follow from reset or extremes
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd1023, 31'd0,     1'b1, rmst_pkg::TOP_VALUE},
        '{rmst_pkg::OP_QUERY, 10'd5,    10'd5,    rmst_pkg::TOP_VALUE, 1'b1,
          rmst_pkg::TOP_VALUE},
        '{rmst_pkg::OP_QUERY, 10'd1023, 10'd0,    31'd0,     1'b1, rmst_pkg::TOP_VALUE},
        '{rmst_pkg::OP_WRITE, 10'd0,    10'd1023, 31'd0,     1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd0,    31'd0,     1'b1, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd1023, 31'd0,     1'b1, 31'd0},
        '{rmst_pkg::OP_WRITE, 10'd1023, 10'd0,    rmst_pkg::TOP_VALUE, 1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd1023, 10'd1023, 31'd0,     1'b1, rmst_pkg::TOP_VALUE},
        '{rmst_pkg::OP_WRITE, 10'd1023, 10'd511,  31'd1,     1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd1,    10'd1023, 31'd0,     1'b1, 31'd1},
        '{rmst_pkg::OP_QUERY, 10'd1023, 10'd1022, 31'd0,     1'b1, rmst_pkg::TOP_VALUE},
        '{rmst_pkg::OP_WRITE, 10'd512,  10'd0,    V_FIVES,   1'b0, 31'd0},
        '{rmst_pkg::OP_WRITE, 10'd511,  10'd0,    V_TWOS,    1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd256,  10'd767,  31'd0,     1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd512,  10'd512,  V_TWOS,    1'b0, 31'd0},
        '{rmst_pkg::OP_WRITE, 10'd0,    10'd0,    V_ALMOST,  1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd511,  31'd0,     1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd1023, V_FIVES,   1'b0, 31'd0},
        '{rmst_pkg::OP_WRITE, 10'd1023, 10'd1023, rmst_pkg::TOP_VALUE, 1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd1,    10'd1022, 31'd0,     1'b0, 31'd0},
        '{rmst_pkg::OP_WRITE, 10'd0,    10'd0,    rmst_pkg::TOP_VALUE, 1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd0,    10'd1023, 31'd0,     1'b0, 31'd0},
        '{rmst_pkg::OP_QUERY, 10'd513,  10'd1023, rmst_pkg::TOP_VALUE, 1'b0, 31'd0}
    };

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             req_valid      = 1'b0;
    logic             req_stall;
    logic             opcode         = rmst_pkg::OP_WRITE;
    rmst_pkg::index_t index_or_start = '0;
    rmst_pkg::index_t range_end      = '0;
    rmst_pkg::value_t new_value      = '0;
    logic             res_valid;
    logic             res_stall      = 1'b0;
    rmst_pkg::value_t minimum;

    rmst_pkg::value_t leaf_values [LEAVES];
    rmst_pkg::value_t pending_minima [$];
    bit               quiet          = 1'b0;
    int               errors         = 0;
    int               results_seen   = 0;
    int               writes_sent    = 0;
    int               queries_sent   = 0;
    int               empty_ranges   = 0;

    range_minimum_segment_tree #(.LEAVES(LEAVES)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .opcode         (opcode),
        .index_or_start (index_or_start),
        .range_end      (range_end),
        .new_value      (new_value),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .minimum        (minimum)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic rmst_pkg::value_t span_minimum(rmst_pkg::index_t first,
                                                      rmst_pkg::index_t last);
        rmst_pkg::value_t best;
        int               hi;
        best = rmst_pkg::TOP_VALUE;
        hi = (int'(last) >= LEAVES) ? LEAVES - 1 : int'(last);
        if (int'(first) < LEAVES)
        begin
            for (int i = int'(first); i <= hi; i++)
            begin
                if (leaf_values[i] < best)
                    best = leaf_values[i];
            end
        end
        return best;
    endfunction

    function automatic void record_request(logic op, rmst_pkg::index_t a,
                                           rmst_pkg::index_t b, rmst_pkg::value_t v,
                                           logic known, rmst_pkg::value_t want);
        if (op == rmst_pkg::OP_WRITE)
        begin
            writes_sent++;
            if (int'(a) < LEAVES)
                leaf_values[a] = v;
        end
        else
        begin
            queries_sent++;
            if (a > b || int'(a) >= LEAVES)
                empty_ranges++;
            pending_minima.push_back(known ? want : span_minimum(a, b));
        end
    endfunction

    task automatic offer_request(logic op, rmst_pkg::index_t a, rmst_pkg::index_t b,
                                 rmst_pkg::value_t v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        opcode         <= op;
        index_or_start <= a;
        range_end      <= b;
        new_value      <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    initial
    begin : request_side
        stim_row_t        row;
        int               item;
        int               base;
        int               span;
        int               style;
        int               pick;
        int               count;
        logic             op;
        rmst_pkg::index_t a;
        rmst_pkg::index_t b;
        rmst_pkg::value_t v;

        foreach (leaf_values[i])
            leaf_values[i] = rmst_pkg::TOP_VALUE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            row = DIRECTED_ROWS[i];
            offer_request(row.op, row.start, row.last, row.value);
            record_request(row.op, row.start, row.last, row.value, row.known, row.want);
        end

        item = 0;
        while (item < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            base  = $urandom_range(0, LEAVES - 1);
            span  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, LEAVES)
                                                : $urandom_range(1, 16);
            style = $urandom_range(0, 2);
            count = $urandom_range(20, 80);
            repeat (count)
            begin
                op   = ($urandom_range(0, 99) < 45) ? rmst_pkg::OP_WRITE
                                                    : rmst_pkg::OP_QUERY;
                pick = $urandom_range(0, 9);
                a    = rmst_pkg::index_t'((base + $urandom_range(0, span - 1)) % LEAVES);
                b    = rmst_pkg::index_t'($urandom);
                if (pick == 0)
                    a = rmst_pkg::index_t'($urandom);
                if (op == rmst_pkg::OP_QUERY)
                begin
                    if (pick == 1 && a > 0)
                        b = rmst_pkg::index_t'($urandom_range(0, int'(a) - 1));
                    else if (pick == 2)
                    begin
                        a = '0;
                        b = rmst_pkg::index_t'(LEAVES - 1);
                    end
                    else if (pick != 0)
                        b = rmst_pkg::index_t'(
                                (int'(a) + $urandom_range(0, span - 1) >= LEAVES)
                                ? LEAVES - 1 : int'(a) + $urandom_range(0, span - 1));
                end
                case (style)
                    0: v = rmst_pkg::value_t'($urandom_range(0, 15));
                    1: v = rmst_pkg::value_t'($urandom);
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: v = '0;
                            1: v = rmst_pkg::TOP_VALUE;
                            2: v = rmst_pkg::TOP_VALUE - 31'd1;
                            default: v = rmst_pkg::value_t'($urandom);
                        endcase
                    end
                endcase
                offer_request(op, a, b, v);
                record_request(op, a, b, v, 1'b0, '0);
                item++;
            end
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_minima.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d writes and %0d queries (%0d empty ranges)",
                 writes_sent, queries_sent, empty_ranges);
        $display("compared %0d minima, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : result_side
        int               stall_left;
        int               long_hold;
        rmst_pkg::value_t want;

        stall_left = 0;
        long_hold  = 0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (pending_minima.size() == 0)
                begin
                    errors++;
                    $display("%0t: minimum mismatch, expected no result, got %h",
                             $time, minimum);
                end
                else
                begin
                    want = pending_minima.pop_front();
                    if (minimum !== want)
                    begin
                        errors++;
                        $display("%0t: minimum mismatch, expected %h, got %h",
                                 $time, want, minimum);
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 7);
                // back up the block so it holds a result and stalls new requests
                if (results_seen == 150 || results_seen == 700)
                    long_hold = LONG_HOLD;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                res_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
